// ----- rtl/trs_pkg.sv -----
`timescale 1ns / 1ps

package trs_pkg;

	localparam int QBITS = 32;

	localparam logic MAT_WORLD = 1'b0;
	localparam logic MAT_INV   = 1'b1;

	typedef struct packed {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
	} item_t;

	typedef struct packed {
		logic       mat;
		logic [1:0] col;
		logic       last;
	} meta_t;

	typedef struct packed {
		logic [63:0]        rem;
		logic [31:0]        dvs;
		logic [QBITS-1:0]   quo;
		logic               neg;
		logic               zero;
		logic               byp;
		logic               ovf;
		logic signed [31:0] val;
	} lane_t;

	typedef struct packed {
		logic            vld;
		meta_t           meta;
		lane_t [2:0]     lane;
	} dstage_t;

endpackage

// ----- rtl/trs_seq.sv -----
`timescale 1ns / 1ps

module trs_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  trs_pkg::item_t in_item,
	output logic           job_vld,
	output logic [2:0]     job_k,
	output trs_pkg::item_t job_item
);
	import trs_pkg::*;

	logic       busy_q;
	logic [2:0] cnt_q;
	item_t      item_q;
	logic       take;

	assign s_tready = adv && (!busy_q || cnt_q == 3'd7);
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= 3'd0;
		end else if (adv && busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= in_item;
		end
	end

	assign job_vld  = busy_q;
	assign job_k    = cnt_q;
	assign job_item = item_q;

endmodule

// ----- rtl/trs_front.sv -----
`timescale 1ns / 1ps

module trs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  logic [2:0]       in_k,
	input  trs_pkg::item_t   in_item,
	output trs_pkg::dstage_t out_stg
);
	import trs_pkg::*;

	localparam logic signed [33:0] ONE = 34'sd536870912;

	function automatic logic signed [31:0] scale_of(input item_t it, input logic [1:0] i);
		logic signed [31:0] r;
		case (i)
			2'd0:    r = it.sx;
			2'd1:    r = it.sy;
			default: r = it.sz;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] move_of(input item_t it, input logic [1:0] i);
		logic signed [31:0] r;
		case (i)
			2'd0:    r = it.tx;
			2'd1:    r = it.ty;
			default: r = it.tz;
		endcase
		return r;
	endfunction

	function automatic logic signed [47:0] rnd16(input logic signed [64:0] p);
		logic [64:0] mag;
		logic [64:0] q;
		mag = p[64] ? 65'(-p) : 65'(p);
		q   = (mag + 65'd32768) >> 16;
		return p[64] ? -48'(q) : 48'(q);
	endfunction

	function automatic logic signed [31:0] rnd29_sat(input logic signed [64:0] p);
		logic [64:0]        mag;
		logic [64:0]        q;
		logic signed [31:0] r;
		mag = p[64] ? 65'(-p) : 65'(p);
		q   = (mag + (65'd1 << 28)) >> 29;
		if (p[64]) begin
			r = (q > 65'h80000000) ? 32'sh80000000 : 32'(-q);
		end else begin
			r = (q > 65'h7fffffff) ? 32'sh7fffffff : 32'(q);
		end
		return r;
	endfunction

	// s1: job
	logic       vld_s1;
	logic [2:0] k_s1;
	item_t      it_s1;

	// s2: quaternion products
	logic               vld_s2;
	logic [2:0]         k_s2;
	item_t              it_s2;
	logic signed [31:0] xx_s2, yy_s2, zz_s2, xy_s2, xz_s2, yz_s2, wx_s2, wy_s2, wz_s2;

	// s3: rotation entries, q3.29
	logic               vld_s3;
	logic [2:0]         k_s3;
	item_t              it_s3;
	logic signed [32:0] r_s3 [0:2][0:2];
	logic signed [32:0] r_n  [0:2][0:2];

	// s4: wide products
	logic               vld_s4;
	logic [2:0]         k_s4;
	item_t              it_s4;
	logic signed [64:0] p_s4    [0:2][0:2];
	logic signed [32:0] rsel_s4 [0:2];
	logic signed [64:0] p_n     [0:2][0:2];
	logic signed [32:0] rsel_n  [0:2];
	logic [1:0]         cidx;

	// s5: rounding
	logic               vld_s5;
	logic [2:0]         k_s5;
	item_t              it_s5;
	logic signed [31:0] w_s5    [0:2];
	logic signed [47:0] d_s5    [0:2][0:2];
	logic signed [32:0] rsel_s5 [0:2];

	// s6: numerators
	logic               vld_s6;
	logic [2:0]         k_s6;
	item_t              it_s6;
	logic signed [55:0] num_s6 [0:2];
	logic signed [31:0] val_s6 [0:2];
	logic signed [55:0] num_n  [0:2];
	logic signed [49:0] dsum   [0:2];

	// s7: magnitudes for the divider
	dstage_t     stg_n;
	logic        vld_s7;
	meta_t       meta_s7;
	lane_t [2:0] lane_s7;

	assign cidx = (k_s3[1:0] == 2'd3) ? 2'd0 : k_s3[1:0];

	always_comb begin
		r_n[0][0] = 33'(ONE - (34'(yy_s2) + 34'(zz_s2)));
		r_n[0][1] = 33'(34'(xy_s2) + 34'(wz_s2));
		r_n[0][2] = 33'(34'(xz_s2) - 34'(wy_s2));
		r_n[1][0] = 33'(34'(xy_s2) - 34'(wz_s2));
		r_n[1][1] = 33'(ONE - (34'(xx_s2) + 34'(zz_s2)));
		r_n[1][2] = 33'(34'(yz_s2) + 34'(wx_s2));
		r_n[2][0] = 33'(34'(xz_s2) + 34'(wy_s2));
		r_n[2][1] = 33'(34'(yz_s2) - 34'(wx_s2));
		r_n[2][2] = 33'(ONE - (34'(xx_s2) + 34'(yy_s2)));
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (!k_s3[2]) begin
				p_n[l][0] = r_s3[cidx][l] * scale_of(it_s3, cidx);
			end else begin
				p_n[l][0] = r_s3[l][0] * it_s3.tx;
			end
			p_n[l][1] = r_s3[l][1] * it_s3.ty;
			p_n[l][2] = r_s3[l][2] * it_s3.tz;
			rsel_n[l] = r_s3[l][cidx];
		end
	end

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			dsum[l] = 50'(d_s5[l][0]) + 50'(d_s5[l][1]) + 50'(d_s5[l][2]);
			if (k_s5 == 3'd7) begin
				num_n[l] = -(56'(dsum[l]) <<< 3);
			end else begin
				num_n[l] = 56'(rsel_s5[l]) <<< 3;
			end
		end
	end

	always_comb begin
		logic signed [31:0] den;
		logic [55:0]        nmag;
		logic [31:0]        dmag;
		stg_n          = '0;
		stg_n.vld      = vld_s6;
		stg_n.meta.mat = k_s6[2] ? MAT_INV : MAT_WORLD;
		stg_n.meta.col = k_s6[1:0];
		stg_n.meta.last = (k_s6 == 3'd7);
		for (int l = 0; l < 3; l++) begin
			den  = scale_of(it_s6, 2'(l));
			nmag = num_s6[l][55] ? 56'(-num_s6[l]) : 56'(num_s6[l]);
			dmag = den[31] ? (~den + 32'd1) : den;
			stg_n.lane[l].rem  = 64'(nmag) + 64'(dmag >> 1);
			stg_n.lane[l].dvs  = dmag;
			stg_n.lane[l].neg  = num_s6[l][55] ^ den[31];
			stg_n.lane[l].zero = (den == 32'sd0);
			stg_n.lane[l].byp  = !k_s6[2];
			stg_n.lane[l].val  = val_s6[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= stg_n.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1  <= in_k;
			it_s1 <= in_item;

			k_s2  <= k_s1;
			it_s2 <= it_s1;
			xx_s2 <= it_s1.qx * it_s1.qx;
			yy_s2 <= it_s1.qy * it_s1.qy;
			zz_s2 <= it_s1.qz * it_s1.qz;
			xy_s2 <= it_s1.qx * it_s1.qy;
			xz_s2 <= it_s1.qx * it_s1.qz;
			yz_s2 <= it_s1.qy * it_s1.qz;
			wx_s2 <= it_s1.qw * it_s1.qx;
			wy_s2 <= it_s1.qw * it_s1.qy;
			wz_s2 <= it_s1.qw * it_s1.qz;

			k_s3  <= k_s2;
			it_s3 <= it_s2;
			r_s3  <= r_n;

			k_s4    <= k_s3;
			it_s4   <= it_s3;
			p_s4    <= p_n;
			rsel_s4 <= rsel_n;

			k_s5    <= k_s4;
			it_s5   <= it_s4;
			rsel_s5 <= rsel_s4;
			for (int l = 0; l < 3; l++) begin
				w_s5[l] <= (k_s4 == 3'd3) ? move_of(it_s4, 2'(l)) : rnd29_sat(p_s4[l][0]);
				for (int m = 0; m < 3; m++) begin
					d_s5[l][m] <= rnd16(p_s4[l][m]);
				end
			end

			k_s6   <= k_s5;
			it_s6  <= it_s5;
			num_s6 <= num_n;
			val_s6 <= w_s5;

			meta_s7 <= stg_n.meta;
			lane_s7 <= stg_n.lane;
		end
	end

	assign out_stg = {vld_s7, meta_s7, lane_s7};

endmodule

// ----- rtl/trs_div_step.sv -----
`timescale 1ns / 1ps

module trs_div_step #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  trs_pkg::dstage_t in_stg,
	output trs_pkg::dstage_t out_stg
);
	import trs_pkg::*;

	dstage_t     nxt;
	logic        vld_q;
	meta_t       meta_q;
	lane_t [2:0] lane_q;
	logic [63:0] sub [0:2];

	generate
		if (STEP == QBITS) begin : g_ovf
			// quotient would not fit: flag it
			always_comb begin
				nxt = in_stg;
				for (int l = 0; l < 3; l++) begin
					sub[l] = {32'd0, in_stg.lane[l].dvs} << STEP;
					if (in_stg.lane[l].rem >= sub[l]) begin
						nxt.lane[l].ovf = 1'b1;
					end
				end
			end
		end else begin : g_bit
			always_comb begin
				nxt = in_stg;
				for (int l = 0; l < 3; l++) begin
					sub[l] = {32'd0, in_stg.lane[l].dvs} << STEP;
					if (in_stg.lane[l].rem >= sub[l]) begin
						nxt.lane[l].rem       = in_stg.lane[l].rem - sub[l];
						nxt.lane[l].quo[STEP] = 1'b1;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= nxt.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q <= nxt.meta;
			lane_q <= nxt.lane;
		end
	end

	assign out_stg = {vld_q, meta_q, lane_q};

endmodule

// ----- rtl/trs_div.sv -----
`timescale 1ns / 1ps

module trs_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  trs_pkg::dstage_t in_stg,
	output trs_pkg::dstage_t out_stg
);
	import trs_pkg::*;

	localparam int NSTEP = QBITS + 1;

	dstage_t chain [0:NSTEP];

	assign chain[0] = in_stg;

	generate
		for (genvar g = 0; g < NSTEP; g++) begin : g_step
			trs_div_step #(
				.STEP(QBITS - g)
			) u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.adv    (adv),
				.in_stg (chain[g]),
				.out_stg(chain[g+1])
			);
		end
	endgenerate

	assign out_stg = chain[NSTEP];

endmodule

// ----- rtl/trs_to_affine_matrix_pair_core.sv -----
// path: the column sequencer, the front stages s1 to s7, the divider steps, then the output register
// each input gives eight result beats, one per cycle while the output is not stalled, world columns then inverse
// the column sequencer takes a new input only when idle or while it issues the last column of the previous one
// the pipeline stalls as a whole while the output register holds an untaken beat
// reset: arst_n clears all valid bits and the sequencer, payload is not cleared
`timescale 1ns / 1ps

module trs_to_affine_matrix_pair_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,  // quat_x, quat_y, quat_z, quat_w, move_x, move_y, move_z,
	                               // size_x, size_y, size_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // entry_row0, entry_row1, entry_row2
	output logic [2:0]   m_tuser,  // which_matrix, column_number
	output logic         m_tlast
);
	import trs_pkg::*;

	item_t              in_item;
	logic               adv;
	logic               job_vld;
	logic [2:0]         job_k;
	item_t              job_item;
	dstage_t            front_stg;
	dstage_t            div_stg;
	logic signed [31:0] ent [0:2];

	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;
	logic [2:0]         m_tuser_q;
	logic               m_tlast_q;

	assign in_item.qx = s_tdata[15:0];
	assign in_item.qy = s_tdata[31:16];
	assign in_item.qz = s_tdata[47:32];
	assign in_item.qw = s_tdata[63:48];
	assign in_item.tx = s_tdata[95:64];
	assign in_item.ty = s_tdata[127:96];
	assign in_item.tz = s_tdata[159:128];
	assign in_item.sx = s_tdata[191:160];
	assign in_item.sy = s_tdata[223:192];
	assign in_item.sz = s_tdata[255:224];

	assign adv = !m_tvalid_q || m_tready;

	trs_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_item (in_item),
		.job_vld (job_vld),
		.job_k   (job_k),
		.job_item(job_item)
	);

	trs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_vld (job_vld),
		.in_k   (job_k),
		.in_item(job_item),
		.out_stg(front_stg)
	);

	trs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_stg (front_stg),
		.out_stg(div_stg)
	);

	// sign and saturate the quotients; bypass lanes pass their value, a zero divisor gives zero
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (div_stg.lane[l].byp) begin
				ent[l] = div_stg.lane[l].val;
			end else if (div_stg.lane[l].zero) begin
				ent[l] = 32'sd0;
			end else if (div_stg.lane[l].neg) begin
				if (div_stg.lane[l].ovf || div_stg.lane[l].quo > 32'h80000000) begin
					ent[l] = 32'sh80000000;
				end else begin
					ent[l] = -div_stg.lane[l].quo;
				end
			end else begin
				if (div_stg.lane[l].ovf || div_stg.lane[l].quo[31]) begin
					ent[l] = 32'sh7fffffff;
				end else begin
					ent[l] = div_stg.lane[l].quo;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= div_stg.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {ent[2], ent[1], ent[0]};
			m_tuser_q <= {div_stg.meta.col, div_stg.meta.mat};
			m_tlast_q <= div_stg.meta.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- rtl/trs_chk.sv -----
`timescale 1ns / 1ps

module trs_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [255:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic [2:0]   m_tuser,
	input logic         m_tlast
);
	import trs_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output beat changed under stall");

	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0] == MAT_INV && m_tuser[2:1] == 2'd3)
		else $error("last beat is not inverse column 3");

	a_one_per_eight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while columns still pending");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input beat changed while waiting");

endmodule

bind trs_to_affine_matrix_pair_core trs_chk u_chk (.*);

// ----- sim/tb_trs_to_affine_matrix_pair_core.sv -----
`timescale 1ns / 1ps

module tb_trs_to_affine_matrix_pair_core;
	import trs_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 460;

	typedef struct packed {
		logic        mat;
		logic [1:0]  col;
		logic [31:0] row0;
		logic [31:0] row1;
		logic [31:0] row2;
		logic        last;
	} column_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	column_t column_fifo[$];
	int          err_count;
	int          items_sent;
	int          columns_seen;
	int          idle_cycles;
	int          rx_wait;
	bit          tx_busy_mode;
	bit          rx_busy_mode;

	trs_to_affine_matrix_pair_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint round_div(longint num, longint den);
		bit neg;
		longint unsigned n;
		longint unsigned d;
		longint unsigned q;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		q = (n + d / 2) / d;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	// expected columns of one transform: world then inverse
	task automatic predict_columns(item_t it);
		longint x, y, z, w;
		longint mv[3];
		longint sc[3];
		longint rot[3][3];
		longint e[3];
		longint d;
		longint one;
		column_t c;
		one = 64'sd1 << 29;
		x = it.qx;
		y = it.qy;
		z = it.qz;
		w = it.qw;
		mv[0] = it.tx;
		mv[1] = it.ty;
		mv[2] = it.tz;
		sc[0] = it.sx;
		sc[1] = it.sy;
		sc[2] = it.sz;
		rot[0][0] = one - (y*y + z*z);
		rot[0][1] = x*y + w*z;
		rot[0][2] = x*z - w*y;
		rot[1][0] = x*y - w*z;
		rot[1][1] = one - (x*x + z*z);
		rot[1][2] = y*z + w*x;
		rot[2][0] = x*z + w*y;
		rot[2][1] = y*z - w*x;
		rot[2][2] = one - (x*x + y*y);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++)
				e[j] = round_div(rot[i][j] * sc[i], one);
			c = '{mat: MAT_WORLD, col: 2'(i), row0: clamp32(e[0]), row1: clamp32(e[1]),
				row2: clamp32(e[2]), last: 1'b0};
			column_fifo.push_back(c);
		end
		c = '{mat: MAT_WORLD, col: 2'd3, row0: it.tx, row1: it.ty, row2: it.tz, last: 1'b0};
		column_fifo.push_back(c);
		for (int j = 0; j < 3; j++) begin
			for (int i = 0; i < 3; i++)
				e[i] = (sc[i] != 0) ? round_div(rot[i][j] * 8, sc[i]) : 0;
			c = '{mat: MAT_INV, col: 2'(j), row0: clamp32(e[0]), row1: clamp32(e[1]),
				row2: clamp32(e[2]), last: 1'b0};
			column_fifo.push_back(c);
		end
		for (int i = 0; i < 3; i++) begin
			d = 0;
			for (int k = 0; k < 3; k++)
				d += round_div(rot[i][k] * mv[k], 64'sd65536);
			e[i] = (sc[i] != 0) ? round_div(-(d * 8), sc[i]) : 0;
		end
		c = '{mat: MAT_INV, col: 2'd3, row0: clamp32(e[0]), row1: clamp32(e[1]),
			row2: clamp32(e[2]), last: 1'b1};
		column_fifo.push_back(c);
	endtask

	task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
		$display("mismatch on %s: expected %h, got %h (column beat %0d)",
			what, exp_v, got_v, columns_seen);
		err_count++;
	endtask

	// one input beat, called at a falling edge
	task automatic send_transform(item_t it);
		int gap;
		gap = tx_busy_mode ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {it.sz, it.sy, it.sx, it.tz, it.ty, it.tx, it.qw, it.qz, it.qy, it.qx};
		do
			@(posedge clk);
		while (!s_tready);
		predict_columns(it);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
			2: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		item_t it;
		// identity rotation, unit scale
		it = '{qx: 0, qy: 0, qz: 0, qw: 16'sh7fff, tx: 32'h00010000, ty: -32'sh20000,
			tz: 32'h00030000, sx: 32'h00010000, sy: 32'h00010000, sz: 32'h00010000};
		send_transform(it);
		// zero scale on all axes
		it.sx = 0; it.sy = 0; it.sz = 0;
		send_transform(it);
		// zero scale on one axis only
		it.sx = 32'h00020000; it.sy = 0; it.sz = -32'sh8000;
		send_transform(it);
		// all fields at the top of their range
		it = '{qx: 16'sh7fff, qy: 16'sh7fff, qz: 16'sh7fff, qw: 16'sh7fff,
			tx: 32'sh7fffffff, ty: 32'sh7fffffff, tz: 32'sh7fffffff,
			sx: 32'sh7fffffff, sy: 32'sh7fffffff, sz: 32'sh7fffffff};
		send_transform(it);
		// all fields at the bottom of their range
		it = '{qx: 16'sh8000, qy: 16'sh8000, qz: 16'sh8000, qw: 16'sh8000,
			tx: 32'sh80000000, ty: 32'sh80000000, tz: 32'sh80000000,
			sx: 32'sh80000000, sy: 32'sh80000000, sz: 32'sh80000000};
		send_transform(it);
		// tiny scale drives the inverse into saturation
		it = '{qx: 0, qy: 16'sh5a82, qz: 0, qw: 16'sh5a82, tx: 32'sh7fffffff,
			ty: 32'sh80000000, tz: 32'h1, sx: 32'h1, sy: -32'sh1, sz: 32'h2};
		send_transform(it);
		// half turn about each axis
		it = '{qx: 16'sh7fff, qy: 0, qz: 0, qw: 0, tx: 32'h00050000, ty: 32'h0,
			tz: -32'sh50000, sx: 32'h00008000, sy: 32'h00020000, sz: -32'sh10000};
		send_transform(it);
		it.qx = 0; it.qy = 16'sh8000;
		send_transform(it);
		it.qy = 0; it.qz = 16'sh7fff;
		send_transform(it);
		// non-unit quaternion, mixed signs
		it = '{qx: 16'sh8000, qy: 16'sh7fff, qz: 16'sh8000, qw: 16'sh7fff,
			tx: 32'h12345678, ty: 32'h9abcdef0, tz: 32'h0fedcba9,
			sx: 32'h00010000, sy: 32'h7fff0000, sz: 32'h80010000};
		send_transform(it);
		// all zero
		it = '0;
		send_transform(it);
	endtask

	task automatic test_random();
		item_t it;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0) begin
				tx_busy_mode = ($urandom_range(0, 3) == 0);
				rx_busy_mode = ($urandom_range(0, 3) == 0);
			end
			it.qx = 16'($urandom);
			it.qy = 16'($urandom);
			it.qz = 16'($urandom);
			it.qw = 16'($urandom);
			if ($urandom_range(0, 1)) begin
				it.tx = $urandom;
				it.ty = $urandom;
				it.tz = $urandom;
			end else begin
				it.tx = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
				it.ty = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
				it.tz = $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
			end
			it.sx = pick_scale();
			it.sy = pick_scale();
			it.sz = pick_scale();
			send_transform(it);
		end
		tx_busy_mode = 1'b0;
		rx_busy_mode = 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait <= rx_wait - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		column_t exp_c;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired with %0d column beats outstanding",
					column_fifo.size());
				$display("Some tests failed");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				rx_wait <= rx_busy_mode ? 0 : $urandom_range(0, 7);
				if (column_fifo.size() == 0) begin
					$display("unexpected column beat");
					err_count++;
				end else begin
					exp_c = column_fifo.pop_front();
					if (m_tuser[0] !== exp_c.mat)
						report_mismatch("which_matrix", 32'(exp_c.mat), 32'(m_tuser[0]));
					if (m_tuser[2:1] !== exp_c.col)
						report_mismatch("column_number", 32'(exp_c.col), 32'(m_tuser[2:1]));
					if (m_tdata[31:0] !== exp_c.row0)
						report_mismatch("entry_row0", exp_c.row0, m_tdata[31:0]);
					if (m_tdata[63:32] !== exp_c.row1)
						report_mismatch("entry_row1", exp_c.row1, m_tdata[63:32]);
					if (m_tdata[95:64] !== exp_c.row2)
						report_mismatch("entry_row2", exp_c.row2, m_tdata[95:64]);
					if (m_tlast !== exp_c.last)
						report_mismatch("final_column", 32'(exp_c.last), 32'(m_tlast));
				end
				columns_seen++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		rx_wait = 0;
		err_count = 0;
		items_sent = 0;
		columns_seen = 0;
		idle_cycles = 0;
		tx_busy_mode = 1'b0;
		rx_busy_mode = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		s_tvalid = 1'b0;
		while (column_fifo.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		$display("sent %0d transforms, checked %0d column beats", items_sent, columns_seen);
		$display("covered identity, half turns, zero and tiny scales, range extremes");
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- trs_to_affine_matrix_pair_core.f -----
rtl/trs_pkg.sv
rtl/trs_seq.sv
rtl/trs_front.sv
rtl/trs_div_step.sv
rtl/trs_div.sv
rtl/trs_to_affine_matrix_pair_core.sv
rtl/trs_chk.sv
sim/tb_trs_to_affine_matrix_pair_core.sv
